// File: sv/pafe_pkg.sv
// Shared types, constants and functions for the PPP async frame encoder.
// No dependencies; imported by the front, queue, back and top modules.
package pafe_pkg;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ADDR_BYTE  = 8'hFF;
  localparam logic [7:0]  CTRL_BYTE  = 8'h03;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [7:0]  CTRL_LIMIT = 8'h20;
  localparam logic [15:0] CHECK_INIT = 16'hFFFF;
  localparam logic [15:0] CHECK_POLY = 16'h8408;

  localparam int NUM_SLOTS = 11;

  // One pending frame segment, produced by the front and expanded by the back
  typedef struct packed {
    logic       hdr;
    logic       has_data;
    logic       data_esc;
    logic [7:0] data_val;
    logic       has_fcs;
    logic       lo_esc;
    logic [7:0] lo_val;
    logic       hi_esc;
    logic [7:0] hi_val;
  } desc_t;

  function automatic logic [15:0] fold_byte(input logic [15:0] chk, input logic [7:0] b);
    logic [15:0] v;
    v = chk ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CHECK_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ADDR_BYTE) || (b == ESC_BYTE) || (b < CTRL_LIMIT);
  endfunction

  localparam logic [15:0] HDR_CHECK = fold_byte(fold_byte(CHECK_INIT, ADDR_BYTE), CTRL_BYTE);

endpackage

// File: sv/pafe_if.sv
// Valid/ready channel interfaces for the PPP async frame encoder.
// No dependencies.
interface pafe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       no_payload;

  modport source (output valid, data_byte, first_byte, last_byte, no_payload, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, no_payload, output ready);
endinterface

interface pafe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       frame_end;

  modport source (output valid, out_byte, run_end, frame_end, input ready);
  modport sink   (input valid, out_byte, run_end, frame_end, output ready);
endinterface

// File: sv/pafe_front.sv
// Front end: accepts payload items, keeps the running FCS-16 and frame state,
// and pushes one segment descriptor per productive item. Uses pafe_pkg, pafe_in_if.
module pafe_front (
  input  logic             clk,
  input  logic             rst_n,
  pafe_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output pafe_pkg::desc_t  push_desc
);
  import pafe_pkg::*;

  logic [15:0] running_check_r, running_check_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic        accept, active, has_data;
  logic [15:0] check_base, check_d, fin;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign active      = in_ch.first_byte || frame_open_r;
  assign has_data    = !in_ch.no_payload;

  always_comb begin
    check_base = in_ch.first_byte ? HDR_CHECK : running_check_r;
    check_d    = has_data ? fold_byte(check_base, in_ch.data_byte) : check_base;
    fin        = ~check_d;
  end

  assign push = accept && active && (in_ch.first_byte || has_data || in_ch.last_byte);

  always_comb begin
    push_desc.hdr      = in_ch.first_byte;
    push_desc.has_data = has_data;
    push_desc.data_esc = needs_escape(in_ch.data_byte);
    push_desc.data_val = in_ch.data_byte;
    push_desc.has_fcs  = in_ch.last_byte;
    push_desc.lo_esc   = needs_escape(fin[7:0]);
    push_desc.lo_val   = fin[7:0];
    push_desc.hi_esc   = needs_escape(fin[15:8]);
    push_desc.hi_val   = fin[15:8];
  end

  always_comb begin
    running_check_nxt = running_check_r;
    frame_open_nxt    = frame_open_r;
    if (accept && active) begin
      if (in_ch.last_byte) begin
        running_check_nxt = CHECK_INIT;
        frame_open_nxt    = 1'b0;
      end else begin
        running_check_nxt = check_d;
        frame_open_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_check_r <= CHECK_INIT;
      frame_open_r    <= 1'b0;
    end else begin
      running_check_r <= running_check_nxt;
      frame_open_r    <= frame_open_nxt;
    end
  end

  // closed frame always leaves the check at its initial value
  assert property (@(posedge clk) disable iff (!rst_n)
    !frame_open_r |-> running_check_r == CHECK_INIT)
    else $error("check not reset while no frame is open");

  // a segment without header only comes from an open frame
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !push_desc.hdr) |-> frame_open_r)
    else $error("segment pushed outside a frame");

endmodule

// File: sv/pafe_queue.sv
// Short descriptor queue between the front and the back.
// Uses pafe_pkg for the descriptor type.
module pafe_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pafe_pkg::desc_t  push_desc,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output pafe_pkg::desc_t  q_desc
);
  import pafe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_desc  = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

// File: sv/pafe_back.sv
// Back end: expands one descriptor into the framed byte stream, one byte per cycle unless stalled.
// Uses pafe_pkg, pafe_out_if.
module pafe_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  pafe_pkg::desc_t  q_desc,
  output logic             pop,
  pafe_out_if.source       out_ch
);
  import pafe_pkg::*;

  localparam int SLOT_OPEN_FLAG = 0;
  localparam int SLOT_ADDR      = 1;
  localparam int SLOT_CTRL_ESC  = 2;
  localparam int SLOT_CTRL      = 3;
  localparam int SLOT_DATA_ESC  = 4;
  localparam int SLOT_DATA      = 5;
  localparam int SLOT_LO_ESC    = 6;
  localparam int SLOT_LO        = 7;
  localparam int SLOT_HI_ESC    = 8;
  localparam int SLOT_HI        = 9;
  localparam int SLOT_CLOSE     = 10;

  logic [NUM_SLOTS-1:0] mask_r, mask_nxt, load_mask, sel;
  logic [7:0]           data_r, lo_r, hi_r;
  logic [7:0]           slot_byte [NUM_SLOTS];
  logic [7:0]           byte_mux;
  logic                 xfer, last_out;

  assign sel      = mask_r & (~mask_r + 1'b1);
  assign last_out = ((mask_r & ~sel) == '0);
  assign xfer     = out_ch.valid && out_ch.ready;
  assign pop      = q_valid && ((mask_r == '0) || (xfer && last_out));

  always_comb begin
    load_mask                 = '0;
    load_mask[SLOT_OPEN_FLAG] = q_desc.hdr;
    load_mask[SLOT_ADDR]      = q_desc.hdr;
    load_mask[SLOT_CTRL_ESC]  = q_desc.hdr;
    load_mask[SLOT_CTRL]      = q_desc.hdr;
    load_mask[SLOT_DATA_ESC]  = q_desc.has_data && q_desc.data_esc;
    load_mask[SLOT_DATA]      = q_desc.has_data;
    load_mask[SLOT_LO_ESC]    = q_desc.has_fcs && q_desc.lo_esc;
    load_mask[SLOT_LO]        = q_desc.has_fcs;
    load_mask[SLOT_HI_ESC]    = q_desc.has_fcs && q_desc.hi_esc;
    load_mask[SLOT_HI]        = q_desc.has_fcs;
    load_mask[SLOT_CLOSE]     = q_desc.has_fcs;
  end

  always_comb begin
    slot_byte[SLOT_OPEN_FLAG] = FLAG_BYTE;
    slot_byte[SLOT_ADDR]      = ADDR_BYTE;
    slot_byte[SLOT_CTRL_ESC]  = ESC_BYTE;
    slot_byte[SLOT_CTRL]      = CTRL_BYTE ^ ESC_XOR;
    slot_byte[SLOT_DATA_ESC]  = ESC_BYTE;
    slot_byte[SLOT_DATA]      = data_r;
    slot_byte[SLOT_LO_ESC]    = ESC_BYTE;
    slot_byte[SLOT_LO]        = lo_r;
    slot_byte[SLOT_HI_ESC]    = ESC_BYTE;
    slot_byte[SLOT_HI]        = hi_r;
    slot_byte[SLOT_CLOSE]     = FLAG_BYTE;
    byte_mux = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) byte_mux = byte_mux | slot_byte[i];
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (pop) mask_nxt = load_mask;
    else if (xfer) mask_nxt = mask_r & ~sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // stuffed values are resolved at load
  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= q_desc.data_esc ? (q_desc.data_val ^ ESC_XOR) : q_desc.data_val;
      lo_r   <= q_desc.lo_esc ? (q_desc.lo_val ^ ESC_XOR) : q_desc.lo_val;
      hi_r   <= q_desc.hi_esc ? (q_desc.hi_val ^ ESC_XOR) : q_desc.hi_val;
    end
  end

  assign out_ch.valid     = (mask_r != '0);
  assign out_ch.out_byte  = byte_mux;
  assign out_ch.run_end   = last_out;
  assign out_ch.frame_end = sel[SLOT_CLOSE];

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.run_end)
    else $error("closing flag not at end of run");

endmodule

// File: sv/ppp_async_frame_encoder_unit.sv
// Top level of the PPP async frame encoder (HDLC-like framing, FCS-16).
// Depends on pafe_pkg, pafe_if, pafe_front, pafe_queue, pafe_back.
//
// Usage:
//   in_ch  : valid/ready sink of payload items (data_byte, first_byte,
//            last_byte, no_payload). An item is transferred when valid and
//            ready are both high.
//   out_ch : valid/ready source of framed bytes (out_byte, run_end,
//            frame_end). run_end flags the last byte an item produced,
//            frame_end the closing flag.
//   Items that produce no output (outside a frame, or empty mid-frame)
//   are absorbed without any output transfer.
// Path: an accepted item is registered in the descriptor queue, then loaded into the back end's slot mask.
// Throughput: the output side emits one byte per cycle while out_ch.ready
//   is high. An item yields 1 output byte for a plain payload byte, 2 for
//   an escaped one, up to 11 for a header plus payload plus check and
//   flag. The front runs ahead by QUEUE_DEPTH items.
// Reset: synchronous, active low; clears frame state, check and queue.
// Stall: when out_ch.ready is low the current byte holds; the queue fills
//   and then in_ch.ready drops.
module ppp_async_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  pafe_in_if.sink     in_ch,
  pafe_out_if.source  out_ch
);
  import pafe_pkg::*;

  logic  push, q_full, pop, q_valid;
  desc_t push_desc, q_desc;

  pafe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  pafe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  pafe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: tb/ppp_async_frame_encoder_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for ppp_async_frame_encoder_unit: drives payload items and checks framed bytes
// against an internal HDLC/FCS-16 framing predictor kept in a small scoreboard class.
// Depends on pafe_pkg (constants), pafe_if (channel interfaces) and the encoder RTL.
module ppp_async_frame_encoder_unit_tb;
  import pafe_pkg::FLAG_BYTE;
  import pafe_pkg::ADDR_BYTE;
  import pafe_pkg::CTRL_BYTE;
  import pafe_pkg::ESC_BYTE;
  import pafe_pkg::ESC_XOR;
  import pafe_pkg::CTRL_LIMIT;
  import pafe_pkg::CHECK_INIT;
  import pafe_pkg::CHECK_POLY;

  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_ITEMS = 150;
  localparam int CALM_FROM    = 120;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       frame_end;
  } wire_byte_t;

  class hdlc_frame_tracker;
    logic [15:0]  fcs;
    bit           in_frame;
    wire_byte_t   pending_wire_bytes[$];
    int unsigned  items_seen;
    int unsigned  bytes_checked;
    int unsigned  frames_closed;
    int unsigned  mismatches;

    function new();
      fcs = CHECK_INIT;
      in_frame = 1'b0;
    endfunction

    static function logic [15:0] fcs16_update(logic [15:0] acc, logic [7:0] b);
      logic [15:0] v;
      v = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        if (v[0]) v = (v >> 1) ^ CHECK_POLY;
        else v = v >> 1;
      end
      return v;
    endfunction

    function void push_raw(logic [7:0] b, logic fe);
      wire_byte_t w;
      w.value = b;
      w.run_end = 1'b0;
      w.frame_end = fe;
      pending_wire_bytes.push_back(w);
    endfunction

    function void push_stuffed(logic [7:0] b);
      if (b == FLAG_BYTE || b == ADDR_BYTE || b == ESC_BYTE || b < CTRL_LIMIT) begin
        push_raw(ESC_BYTE, 1'b0);
        push_raw(b ^ ESC_XOR, 1'b0);
      end else begin
        push_raw(b, 1'b0);
      end
    endfunction

    // Works out the framed bytes one accepted item causes.
    function void absorb_payload_item(logic [7:0] data, logic is_first, logic is_last,
                                      logic is_empty);
      int start;
      logic [15:0] fin;
      start = pending_wire_bytes.size();
      items_seen++;
      if (!is_first && !in_frame) return;
      if (is_first) begin
        fcs = fcs16_update(fcs16_update(CHECK_INIT, ADDR_BYTE), CTRL_BYTE);
        in_frame = 1'b1;
        push_raw(FLAG_BYTE, 1'b0);
        push_raw(ADDR_BYTE, 1'b0);
        push_raw(ESC_BYTE, 1'b0);
        push_raw(CTRL_BYTE ^ ESC_XOR, 1'b0);
      end
      if (!is_empty) begin
        fcs = fcs16_update(fcs, data);
        push_stuffed(data);
      end
      if (is_last) begin
        fin = fcs ^ 16'hFFFF;
        push_stuffed(fin[7:0]);
        push_stuffed(fin[15:8]);
        push_raw(FLAG_BYTE, 1'b1);
        fcs = CHECK_INIT;
        in_frame = 1'b0;
        frames_closed++;
      end
      if (pending_wire_bytes.size() > start)
        pending_wire_bytes[pending_wire_bytes.size() - 1].run_end = 1'b1;
    endfunction

    function void match_wire_byte(logic [7:0] b, logic re, logic fe);
      wire_byte_t w;
      bytes_checked++;
      if (pending_wire_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %02h run_end %0b frame_end %0b, nothing pending",
                   b, re, fe);
        return;
      end
      w = pending_wire_bytes.pop_front();
      if (w.value !== b || w.run_end !== re || w.frame_end !== fe) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte %0d: expected %02h run_end %0b frame_end %0b, got %02h %0b %0b",
                   bytes_checked, w.value, w.run_end, w.frame_end, b, re, fe);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idling;
  int   quiet_cycles;

  pafe_in_if  in_ch();
  pafe_out_if out_ch();

  hdlc_frame_tracker tracker;

  ppp_async_frame_encoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitor: inputs before outputs within one edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.absorb_payload_item(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte,
                                    in_ch.no_payload);
      if (out_ch.valid && out_ch.ready)
        tracker.match_wire_byte(out_ch.out_byte, out_ch.run_end, out_ch.frame_end);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (idling && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("ppp_async_frame_encoder_unit regression: fail");
    $finish;
  end

  task automatic drive_item(input logic [7:0] data, input logic is_first, input logic is_last,
                            input logic is_empty);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data;
    in_ch.first_byte <= is_first;
    in_ch.last_byte  <= is_last;
    in_ch.no_payload <= is_empty;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame(input logic [7:0] body[$]);
    for (int k = 0; k < body.size(); k++)
      drive_item(body[k], k == 0, k == body.size() - 1, 1'b0);
  endtask

  initial begin
    logic [7:0] specials[8];
    logic [7:0] data;
    logic       is_first, is_last, is_empty;
    int         counted, kind, len;
    int         errors;

    specials = '{8'h00, 8'h1F, 8'h20, 8'h7D, 8'h7E, 8'hFF, 8'h5E, 8'h7F};
    tracker = new();
    quiet_cycles = 0;
    idling = 1'b1;
    rst_n <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    in_ch.no_payload <= 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // stray items with no frame open
    drive_item(8'h55, 1'b0, 1'b0, 1'b0);
    drive_item(8'hAA, 1'b0, 1'b1, 1'b1);
    // empty packet
    drive_item(8'h00, 1'b1, 1'b1, 1'b1);
    // every escape class and its neighbors
    send_frame('{8'h00, 8'hFF, 8'h7E, 8'h7D, 8'h1F, 8'h20, 8'h7F, 8'h80});
    send_frame('{8'hAA});
    // restart inside an open frame, empty mid item, empty closing item
    drive_item(8'h41, 1'b1, 1'b0, 1'b0);
    drive_item(8'h42, 1'b1, 1'b0, 1'b0);
    drive_item(8'h13, 1'b0, 1'b0, 1'b1);
    drive_item(8'h7E, 1'b0, 1'b0, 1'b0);
    drive_item(8'hFF, 1'b0, 1'b1, 1'b1);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= CALM_FROM) idling = 1'b0;
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 8);
      if (kind == 0) begin
        drive_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        for (int k = 0; k < len; k++) begin
          data = ($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 7)] : 8'($urandom);
          is_first = (k == 0);
          is_last = (k == len - 1);
          is_empty = 1'b0;
          if (kind == 1 && is_last) is_empty = 1'b1;
          if (kind == 2 && !is_first && !is_last) is_empty = 1'($urandom_range(0, 1));
          if (kind == 3 && is_last && len > 1) is_last = 1'b0;
          if (kind == 4 && len == 1) is_empty = 1'b1;
          drive_item(data, is_first, is_last, is_empty);
          counted++;
        end
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (tracker.pending_wire_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input transfers over %0d closed frames, %0d output bytes checked",
             tracker.items_seen, tracker.frames_closed, tracker.bytes_checked);
    errors = tracker.mismatches + tracker.pending_wire_bytes.size();
    if (tracker.pending_wire_bytes.size() != 0)
      $display("%0d expected output bytes never arrived", tracker.pending_wire_bytes.size());
    if (errors == 0) begin
      $display("ppp_async_frame_encoder_unit regression: pass");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("ppp_async_frame_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule
